@@ rtl/spa_pkg.sv @@
// Package with the shared constants, codes and control types of the sparse polynomial adder.
package spa_pkg;

    localparam int MAX_TERMS = 32;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_ADD    = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_TERM   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_FULL   = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    // Operation applied to a whole term chain.
    typedef struct packed {
        logic load;
        logic rotate;
        logic clear;
    } spa_chain_ctl_t;

    // Operation applied to one cell of a chain.
    typedef struct packed {
        logic insert;
        logic rotate;
    } spa_cell_ctl_t;

endpackage

@@ rtl/spa_cell.sv @@
// One term slot of a chain: holds a coefficient and an exponent and shifts with its neighbors.
module spa_cell
    import spa_pkg::*;
(
    input  logic                clk,
    input  spa_cell_ctl_t       ctl,
    input  logic                occ,
    input  logic                tail,
    input  logic                left_ge,
    input  logic signed [15:0]  new_coef,
    input  logic        [7:0]   new_expo,
    input  logic signed [15:0]  left_coef,
    input  logic        [7:0]   left_expo,
    input  logic signed [15:0]  right_coef,
    input  logic        [7:0]   right_expo,
    input  logic signed [15:0]  head_coef,
    input  logic        [7:0]   head_expo,
    output logic signed [15:0]  coef,
    output logic        [7:0]   expo,
    output logic                ge
);

    logic signed [15:0] coef_reg;
    logic signed [15:0] coef_next;
    logic        [7:0]  expo_reg;
    logic        [7:0]  expo_next;

    // An occupied slot whose exponent is not below the new one stays in place.
    assign ge = occ && (expo_reg >= new_expo);

    always_comb
    begin
        coef_next = coef_reg;
        expo_next = expo_reg;
        if (ctl.insert)
        begin
            if (!ge)
            begin
                if (left_ge)
                begin
                    coef_next = new_coef;
                    expo_next = new_expo;
                end
                else
                begin
                    coef_next = left_coef;
                    expo_next = left_expo;
                end
            end
        end
        else if (ctl.rotate)
        begin
            if (tail)
            begin
                coef_next = head_coef;
                expo_next = head_expo;
            end
            else
            begin
                coef_next = right_coef;
                expo_next = right_expo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        expo_reg <= expo_next;
    end

    assign coef = coef_reg;
    assign expo = expo_reg;

endmodule

@@ rtl/spa_chain.sv @@
// A row of term cells kept in descending exponent order, with its fill count.
module spa_chain
    import spa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  spa_chain_ctl_t      ctl,
    input  logic signed [15:0]  new_coef,
    input  logic        [7:0]   new_expo,
    output logic signed [15:0]  head_coef,
    output logic        [7:0]   head_expo,
    output logic [CNT_W-1:0]    count,
    output logic                full
);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic signed [15:0] coef_w [MAX_TERMS];
    logic        [7:0]  expo_w [MAX_TERMS];
    logic               ge_w   [MAX_TERMS];
    spa_cell_ctl_t      cell_ctl;

    assign full = (count_reg == CNT_W'(MAX_TERMS));
    assign cell_ctl.insert = ctl.load && !full;
    assign cell_ctl.rotate = ctl.rotate;

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
            count_next = '0;
        else if (cell_ctl.insert)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    for (genvar i = 0; i < MAX_TERMS; i++)
    begin : g_cell
        logic               occ;
        logic               tail;
        logic               left_ge;
        logic signed [15:0] left_coef;
        logic        [7:0]  left_expo;
        logic signed [15:0] right_coef;
        logic        [7:0]  right_expo;

        assign occ  = CNT_W'(i) < count_reg;
        assign tail = CNT_W'(i + 1) == count_reg;

        if (i == 0)
        begin : g_first
            assign left_ge   = 1'b1;
            assign left_coef = new_coef;
            assign left_expo = new_expo;
        end
        else
        begin : g_inner
            assign left_ge   = ge_w[i-1];
            assign left_coef = coef_w[i-1];
            assign left_expo = expo_w[i-1];
        end

        if (i == MAX_TERMS - 1)
        begin : g_last
            assign right_coef = coef_w[0];
            assign right_expo = expo_w[0];
        end
        else
        begin : g_body
            assign right_coef = coef_w[i+1];
            assign right_expo = expo_w[i+1];
        end

        spa_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .occ        (occ),
            .tail       (tail),
            .left_ge    (left_ge),
            .new_coef   (new_coef),
            .new_expo   (new_expo),
            .left_coef  (left_coef),
            .left_expo  (left_expo),
            .right_coef (right_coef),
            .right_expo (right_expo),
            .head_coef  (coef_w[0]),
            .head_expo  (expo_w[0]),
            .coef       (coef_w[i]),
            .expo       (expo_w[i]),
            .ge         (ge_w[i])
        );
    end

    assign head_coef = coef_w[0];
    assign head_expo = expo_w[0];
    assign count     = count_reg;

endmodule

@@ rtl/sparse_polynomial_adder_core.sv @@
// Top level of the sparse polynomial adder: command decode, merge sequencer and result register.
//
// The block keeps two sparse polynomials, A and B, each in a chain of term cells held in
// descending exponent order. Input items carry a command, a coefficient and an exponent on
// a valid/ready channel; result items leave on a second valid/ready channel.
// A load into A or B inserts the term in parallel: every cell decides on its own whether
// to keep its term, take the new one or take its left neighbor's. Its single result item
// (accepted or table full) is valid in the cycle after the item is accepted.
// An add walks both chains head first. Each merge step pops the head of A, of B or of both,
// and the popped chain rotates by one cell so the next term reaches its head; after the
// add each chain has turned once around and holds its terms unchanged. One sum term leaves
// per cycle while the result register is free; an add emits count_a + count_b terms at
// most (one merge step per emitted term, up to 2*MAX_TERMS). With both tables empty an
// add gives one empty result in the cycle after it is accepted. A clear empties both
// counts and gives no result.
// One item is worked on at a time: in_ready is high only while no add is in progress and
// the result register is free or being emptied. When the receiver stalls, the result
// register holds its item and the merge waits without losing a step.
// Reset clears both counts, the sequencer state and the result valid flag; the table
// contents need no clearing because only entries below the counts are ever read.
module sparse_polynomial_adder_core
    import spa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          command,
    input  logic signed [15:0]  coef,
    input  logic [7:0]          expo,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          kind,
    output logic signed [16:0]  sum_coef,
    output logic [7:0]          sum_expo,
    output logic                last
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   ia_reg;
    logic [CNT_W-1:0]   ia_next;
    logic [CNT_W-1:0]   ib_reg;
    logic [CNT_W-1:0]   ib_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         kind_reg;
    logic [1:0]         kind_next;
    logic signed [16:0] sum_coef_reg;
    logic signed [16:0] sum_coef_next;
    logic [7:0]         sum_expo_reg;
    logic [7:0]         sum_expo_next;
    logic               last_reg;
    logic               last_next;

    spa_chain_ctl_t     ctl_a;
    spa_chain_ctl_t     ctl_b;
    logic signed [15:0] a_coef;
    logic        [7:0]  a_expo;
    logic signed [15:0] b_coef;
    logic        [7:0]  b_expo;
    logic [CNT_W-1:0]   count_a;
    logic [CNT_W-1:0]   count_b;
    logic               full_a;
    logic               full_b;

    logic               out_free;
    logic               accept;
    logic               step;
    logic               a_has;
    logic               b_has;
    logic               pop_a;
    logic               pop_b;
    logic               a_more;
    logic               b_more;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign step     = (state_reg == ST_MERGE) && out_free;

    // Merge decision on the two chain heads.
    assign a_has = ia_reg < count_a;
    assign b_has = ib_reg < count_b;

    always_comb
    begin
        pop_a = 1'b0;
        pop_b = 1'b0;
        if (a_has && b_has && (a_expo == b_expo))
        begin
            pop_a = 1'b1;
            pop_b = 1'b1;
        end
        else if (!b_has || (a_has && (a_expo > b_expo)))
            pop_a = 1'b1;
        else
            pop_b = 1'b1;
    end

    assign a_more = pop_a ? ((ia_reg + 1'b1) < count_a) : a_has;
    assign b_more = pop_b ? ((ib_reg + 1'b1) < count_b) : b_has;

    assign ctl_a.load   = accept && (command == CMD_LOAD_A);
    assign ctl_a.rotate = step && pop_a;
    assign ctl_a.clear  = accept && (command == CMD_CLEAR);
    assign ctl_b.load   = accept && (command == CMD_LOAD_B);
    assign ctl_b.rotate = step && pop_b;
    assign ctl_b.clear  = accept && (command == CMD_CLEAR);

    always_comb
    begin
        state_next     = state_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        sum_coef_next  = sum_coef_reg;
        sum_expo_next  = sum_expo_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_LOAD_A, CMD_LOAD_B:
                        begin
                            out_valid_next = 1'b1;
                            sum_coef_next  = '0;
                            sum_expo_next  = '0;
                            last_next      = 1'b1;
                            if ((command == CMD_LOAD_A) ? full_a : full_b)
                                kind_next = KIND_FULL;
                            else
                                kind_next = KIND_ACCEPT;
                        end
                        CMD_ADD:
                        begin
                            if ((count_a == '0) && (count_b == '0))
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = KIND_EMPTY;
                                sum_coef_next  = '0;
                                sum_expo_next  = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_MERGE;
                                ia_next    = '0;
                                ib_next    = '0;
                            end
                        end
                        default:
                        begin
                            // Clear: the chains drop their counts, no result.
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                if (step)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_TERM;
                    last_next      = !(a_more || b_more);
                    if (pop_a && pop_b)
                    begin
                        sum_coef_next = 17'(a_coef) + 17'(b_coef);
                        sum_expo_next = a_expo;
                    end
                    else if (pop_a)
                    begin
                        sum_coef_next = 17'(a_coef);
                        sum_expo_next = a_expo;
                    end
                    else
                    begin
                        sum_coef_next = 17'(b_coef);
                        sum_expo_next = b_expo;
                    end
                    if (pop_a)
                        ia_next = ia_reg + 1'b1;
                    if (pop_b)
                        ib_next = ib_reg + 1'b1;
                    if (!(a_more || b_more))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ia_reg        <= '0;
            ib_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ia_reg        <= ia_next;
            ib_reg        <= ib_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload carries no reset; out_valid_reg qualifies it.
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sum_coef_reg <= sum_coef_next;
        sum_expo_reg <= sum_expo_next;
        last_reg     <= last_next;
    end

    spa_chain u_chain_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_a),
        .new_coef  (coef),
        .new_expo  (expo),
        .head_coef (a_coef),
        .head_expo (a_expo),
        .count     (count_a),
        .full      (full_a)
    );

    spa_chain u_chain_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_b),
        .new_coef  (coef),
        .new_expo  (expo),
        .head_coef (b_coef),
        .head_expo (b_expo),
        .count     (count_b),
        .full      (full_b)
    );

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign sum_coef  = sum_coef_reg;
    assign sum_expo  = sum_expo_reg;
    assign last      = last_reg;

endmodule

@@ rtl/spa_checker.sv @@
// Port-level checker for the sparse polynomial adder core, bound to the top level.
module spa_checker
    import spa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [1:0]          command,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [1:0]          kind,
    input  logic signed [16:0]  sum_coef,
    input  logic [7:0]          sum_expo,
    input  logic                last
);

    // A stalled result item holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(sum_coef)
            && $stable(sum_expo) && $stable(last))
        else $error("stalled result item changed");

    // Only sum terms can be followed by more results of the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_TERM) |-> last)
        else $error("non-term result without last mark");

    // Status results carry a zero coefficient and exponent.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_TERM) |-> (sum_coef == 17'sd0) && (sum_expo == 8'd0))
        else $error("status result with nonzero payload");

    // A load gives its status result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && ((command == CMD_LOAD_A) || (command == CMD_LOAD_B))
            |=> out_valid && last && ((kind == KIND_ACCEPT) || (kind == KIND_FULL)))
        else $error("load without status result");

endmodule

bind sparse_polynomial_adder_core spa_checker u_spa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .sum_coef  (sum_coef),
    .sum_expo  (sum_expo),
    .last      (last)
);

@@ verif/sparse_polynomial_adder_core_tb.sv @@
// Self-checking testbench for the sparse polynomial adder core with random handshake idling.
`timescale 1ns / 100ps

module sparse_polynomial_adder_core_tb;
    import spa_pkg::*;

    localparam int RANDOM_ITEMS = 100;
    localparam int DRAIN_CYCLES = 4 * MAX_TERMS;
    localparam int CYCLE_LIMIT  = 1_500_000;

    // One input item as the sender presents it.
    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] coef;
        logic [7:0]         expo;
    } poly_cmd_t;

    // One result item as the receiver sees it.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [16:0] sum_coef;
        logic [7:0]         sum_expo;
        logic               last;
    } poly_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         command = CMD_CLEAR;
    logic signed [15:0] coef = '0;
    logic [7:0]         expo = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         kind;
    logic signed [16:0] sum_coef;
    logic [7:0]         sum_expo;
    logic               last;

    poly_cmd_t    pending_cmds[$];
    poly_result_t expected_results[$];

    // Shadow copy of both term tables: index 0 is A, index 1 is B.
    logic signed [15:0] term_coef[2][MAX_TERMS];
    logic [7:0]         term_expo[2][MAX_TERMS];
    int                 term_count[2];

    int          failures = 0;
    int          cycles = 0;
    int          items_queued = 0;
    bit          calm_stretch = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;

    sparse_polynomial_adder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .coef      (coef),
        .expo      (expo),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .sum_coef  (sum_coef),
        .sum_expo  (sum_expo),
        .last      (last)
    );

    always #2 clk = ~clk;

    // Idle length: mostly none or short, now and then long, and none at all
    // during a calm stretch so that back-to-back traffic is seen too.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_stretch || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Coefficients lean on the two extremes so the widened sum hits its limits.
    function automatic logic signed [15:0] pick_coef();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sh7FFF;
        else if (r == 1)
            return 16'sh8000;
        else
            return 16'($urandom);
    endfunction

    // A narrow exponent range makes equal exponents in and across tables common.
    function automatic logic [7:0] pick_expo();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'($urandom_range(0, 7));
        else if (r == 4)
            return 8'hFF;
        else if (r == 5)
            return 8'h00;
        else
            return 8'($urandom);
    endfunction

    task automatic queue_cmd(input logic [1:0] cmd, input logic signed [15:0] c,
                             input logic [7:0] e);
        poly_cmd_t it;
        it.command = cmd;
        it.coef    = c;
        it.expo    = e;
        pending_cmds.push_back(it);
        items_queued++;
    endtask

    // Applies one accepted item to the shadow tables and queues the results it causes.
    task automatic predict_command(input logic [1:0] cmd, input logic signed [15:0] c,
                                   input logic [7:0] e);
        int t;
        int n;
        int pos;
        int i;
        int j;
        logic signed [16:0] acc;
        poly_result_t r;
        r      = '0;
        r.last = 1'b1;
        case (cmd)
            CMD_LOAD_A, CMD_LOAD_B:
            begin
                t = (cmd == CMD_LOAD_A) ? 0 : 1;
                n = term_count[t];
                if (n >= MAX_TERMS) begin
                    r.kind = KIND_FULL;
                end
                else begin
                    // The new term goes after every term of equal or higher exponent.
                    pos = 0;
                    while (pos < n && term_expo[t][pos] >= e)
                        pos++;
                    for (i = n; i > pos; i--) begin
                        term_coef[t][i] = term_coef[t][i - 1];
                        term_expo[t][i] = term_expo[t][i - 1];
                    end
                    term_coef[t][pos] = c;
                    term_expo[t][pos] = e;
                    term_count[t]     = n + 1;
                    r.kind            = KIND_ACCEPT;
                end
                expected_results.push_back(r);
            end
            CMD_ADD:
            begin
                if (term_count[0] == 0 && term_count[1] == 0) begin
                    r.kind = KIND_EMPTY;
                    expected_results.push_back(r);
                end
                else begin
                    i = 0;
                    j = 0;
                    while (i < term_count[0] || j < term_count[1]) begin
                        if (i < term_count[0] && j < term_count[1] &&
                            term_expo[0][i] == term_expo[1][j]) begin
                            // Only the first unmatched term of each side pairs up.
                            acc        = term_coef[0][i];
                            acc        = acc + term_coef[1][j];
                            r.sum_expo = term_expo[0][i];
                            i++;
                            j++;
                        end
                        else if (j >= term_count[1] ||
                                 (i < term_count[0] && term_expo[0][i] > term_expo[1][j])) begin
                            acc        = term_coef[0][i];
                            r.sum_expo = term_expo[0][i];
                            i++;
                        end
                        else begin
                            acc        = term_coef[1][j];
                            r.sum_expo = term_expo[1][j];
                            j++;
                        end
                        r.kind     = KIND_TERM;
                        r.sum_coef = acc;
                        r.last     = (i >= term_count[0] && j >= term_count[1]);
                        expected_results.push_back(r);
                    end
                end
            end
            CMD_CLEAR:
            begin
                term_count[0] = 0;
                term_count[1] = 0;
            end
        endcase
    endtask

    // Sender: presents the next queued item after its idle gap and holds it until taken.
    always @(posedge clk) begin : sender
        poly_cmd_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0) begin
                nxt      = pending_cmds.pop_front();
                command  <= nxt.command;
                coef     <= nxt.coef;
                expo     <= nxt.expo;
                in_valid <= 1'b1;
                send_gap <= idle_len();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: drops ready for random stretches, including while a result is waiting.
    always @(posedge clk) begin
        if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
            out_ready  <= 1'b0;
        end
        else begin
            out_ready  <= 1'b1;
            recv_stall <= ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        end
    end

    // Monitor: predicts on every accepted input item, then checks every accepted result.
    always @(posedge clk) begin : monitor
        poly_result_t want;
        if (rst_n) begin
            if (in_valid && in_ready)
                predict_command(command, coef, expo);
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: kind %0d sum_coef %0d sum_expo %0d last %0d",
                           kind, sum_coef, sum_expo, last);
                    failures++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, kind);
                        failures++;
                    end
                    if (sum_coef !== want.sum_coef) begin
                        $error("sum_coef: expected %0d, actual %0d", want.sum_coef, sum_coef);
                        failures++;
                    end
                    if (sum_expo !== want.sum_expo) begin
                        $error("sum_expo: expected %0d, actual %0d", want.sum_expo, sum_expo);
                        failures++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        failures++;
                    end
                end
            end
        end
    end

    // Cycle count, calm stretches and the overall timeout.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles % 256 == 255)
            calm_stretch <= ($urandom_range(0, 3) == 0);
        if (cycles >= CYCLE_LIMIT) begin
            $display("[sparse_polynomial_adder_core] ERROR");
            $finish;
        end
    end

    initial begin
        int n_loads;
        int fill_table;
        bit fill_run;
        int k;
        logic [1:0] load_cmd;

        term_count[0] = 0;
        term_count[1] = 0;

        // Directed part: empty add, extreme coefficients and exponents, equal
        // exponents within a table, a zero sum, one-sided terms, and clears.
        queue_cmd(CMD_ADD, 16'sh0000, 8'h00);
        queue_cmd(CMD_CLEAR, 16'sh7FFF, 8'hFF);
        queue_cmd(CMD_LOAD_A, 16'sh7FFF, 8'hFF);
        queue_cmd(CMD_LOAD_A, 16'sh8000, 8'h00);
        queue_cmd(CMD_LOAD_A, 16'sh0064, 8'hFF);
        queue_cmd(CMD_LOAD_B, 16'sh7FFF, 8'hFF);
        queue_cmd(CMD_LOAD_B, 16'sh8000, 8'h00);
        queue_cmd(CMD_LOAD_B, 16'sh0007, 8'h80);
        queue_cmd(CMD_LOAD_A, -16'sh0007, 8'h80);
        queue_cmd(CMD_LOAD_B, 16'sh0001, 8'h40);
        queue_cmd(CMD_LOAD_A, 16'sh0003, 8'hC8);
        queue_cmd(CMD_ADD, 16'sh0000, 8'h00);
        queue_cmd(CMD_ADD, 16'sh8000, 8'hFF);
        queue_cmd(CMD_CLEAR, 16'sh0000, 8'h00);
        queue_cmd(CMD_ADD, 16'sh0000, 8'h00);
        queue_cmd(CMD_LOAD_B, -16'sh0001, 8'h01);
        queue_cmd(CMD_ADD, 16'sh0000, 8'h00);
        queue_cmd(CMD_CLEAR, 16'sh0000, 8'h00);
        queue_cmd(CMD_LOAD_A, 16'sh0001, 8'h00);
        queue_cmd(CMD_ADD, 16'sh0000, 8'h00);
        queue_cmd(CMD_CLEAR, 16'sh0000, 8'h00);

        // Random part: load sequences closed by an add, sometimes opened by a
        // clear, with stray commands in between. The first sequence overfills
        // one table so the table-full drop is always reached.
        fill_run = 1'b1;
        k = items_queued;
        while (items_queued - k < RANDOM_ITEMS) begin
            if (fill_run || $urandom_range(0, 9) == 0) begin
                n_loads    = MAX_TERMS + 2;
                fill_table = $urandom_range(0, 1);
            end
            else begin
                n_loads    = $urandom_range(0, 8);
                fill_table = -1;
            end
            fill_run = 1'b0;
            if ($urandom_range(0, 3) == 0)
                queue_cmd(CMD_CLEAR, pick_coef(), pick_expo());
            repeat (n_loads) begin
                if (fill_table == 0)
                    load_cmd = CMD_LOAD_A;
                else if (fill_table == 1)
                    load_cmd = CMD_LOAD_B;
                else
                    load_cmd = $urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A;
                queue_cmd(load_cmd, pick_coef(), pick_expo());
            end
            queue_cmd(CMD_ADD, 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 4) == 0)
                queue_cmd(2'($urandom), 16'($urandom), 8'($urandom));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item is taken and every result has come back.
        while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        // Any result that shows up now is extra and fails in the monitor.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("[sparse_polynomial_adder_core] OK");
        else
            $display("[sparse_polynomial_adder_core] ERROR");
        $finish;
    end

endmodule
